@@ rtl/clr_pkg.sv @@
// Shared types and constants for the clipped line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

	localparam int COORD_W = 16;
	localparam int SPAN_W  = 17;
	localparam int ERR_W   = 19;
	localparam int COLOR_W = 24;
	localparam int INDEX_W = 21;
	localparam int CLIP_W  = 11;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USER_W = 2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic                opcode;
		coord_t              x_start;
		coord_t              y_start;
		coord_t              x_end;
		coord_t              y_end;
		logic [COLOR_W-1:0]  stroke_color;
	} line_item_t;

	typedef struct packed {
		coord_t                    cur_x;
		coord_t                    cur_y;
		coord_t                    tgt_x;
		coord_t                    tgt_y;
		logic [SPAN_W-1:0]         span_x;
		logic [SPAN_W-1:0]         span_y;
		logic                      neg_x;
		logic                      neg_y;
		logic signed [ERR_W-1:0]   err;
		logic [COLOR_W-1:0]        color;
	} line_state_t;

	typedef struct packed {
		logic                pixel_visible;
		logic [INDEX_W-1:0]  pixel_index;
		logic [COLOR_W-1:0]  pixel_color;
		logic                line_done;
	} pixel_result_t;

endpackage

`default_nettype wire

@@ rtl/clr_setup.sv @@
// Line setup: spans, step directions and initial error from a load transfer.
`timescale 1ns / 1ps
`default_nettype none

module clr_setup (
	input  var clr_pkg::line_item_t  item,
	output var clr_pkg::line_state_t state
);
	import clr_pkg::*;

	logic signed [SPAN_W-1:0] dx;
	logic signed [SPAN_W-1:0] dy;
	logic [SPAN_W-1:0]        sx;
	logic [SPAN_W-1:0]        sy;

	always_comb begin
		dx = {item.x_start[COORD_W-1], item.x_start} - {item.x_end[COORD_W-1], item.x_end};
		dy = {item.y_start[COORD_W-1], item.y_start} - {item.y_end[COORD_W-1], item.y_end};
		sx = dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
		sy = dy[SPAN_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);

		state.cur_x  = item.x_start;
		state.cur_y  = item.y_start;
		state.tgt_x  = item.x_end;
		state.tgt_y  = item.y_end;
		state.span_x = sx;
		state.span_y = sy;
		state.neg_x  = !(item.x_start < item.x_end);
		state.neg_y  = !(item.y_start < item.y_end);
		state.err    = $signed(ERR_W'(sx)) - $signed(ERR_W'(sy));
		state.color  = item.stroke_color;
	end

endmodule

`default_nettype wire

@@ rtl/clr_step.sv @@
// Step unit: clip test, frame index and Bresenham point advance.
`timescale 1ns / 1ps
`default_nettype none

module clr_step #(
	parameter int FRAME_WIDTH  = 2048,
	parameter int FRAME_HEIGHT = 1024
) (
	input  var clr_pkg::line_state_t   state,
	input  var logic [10:0]            clip_left,
	output var clr_pkg::pixel_result_t result,
	output var clr_pkg::line_state_t   next_state
);
	import clr_pkg::*;

	localparam logic signed [COORD_W:0] FW = (COORD_W+1)'(FRAME_WIDTH);
	localparam logic signed [COORD_W:0] FH = (COORD_W+1)'(FRAME_HEIGHT);
	localparam int PROD_W = 25;

	logic                     done;
	logic                     vis;
	logic signed [COORD_W:0]  xw;
	logic signed [COORD_W:0]  yw;
	logic signed [COORD_W:0]  clip_w;
	logic [PROD_W-1:0]        row_base;
	logic signed [ERR_W:0]    e2;
	logic                     move_x;
	logic                     move_y;
	logic signed [ERR_W-1:0]  err_n;

	always_comb begin
		done     = (state.cur_x == state.tgt_x) && (state.cur_y == state.tgt_y);
		xw       = {state.cur_x[COORD_W-1], state.cur_x};
		yw       = {state.cur_y[COORD_W-1], state.cur_y};
		clip_w   = $signed((COORD_W+1)'(clip_left));
		vis      = (xw >= clip_w) && (xw < FW) && !yw[COORD_W] && (yw < FH);
		row_base = PROD_W'(state.cur_y[11:0]) * PROD_W'(FRAME_WIDTH);

		e2     = {state.err, 1'b0};
		move_x = e2 > -$signed((ERR_W+1)'(state.span_y));
		move_y = e2 < $signed((ERR_W+1)'(state.span_x));
		err_n  = state.err;
		if (move_x) begin
			err_n = err_n - $signed(ERR_W'(state.span_y));
		end
		if (move_y) begin
			err_n = err_n + $signed(ERR_W'(state.span_x));
		end

		result.line_done     = done;
		result.pixel_visible = !done && vis;
		result.pixel_index   = (!done && vis) ?
			INDEX_W'(row_base) + INDEX_W'(state.cur_x[11:0]) : '0;
		result.pixel_color   = done ? '0 : state.color;

		next_state = state;
		if (!done) begin
			next_state.err = err_n;
			if (move_x) begin
				next_state.cur_x = state.neg_x ? state.cur_x - 16'sd1 : state.cur_x + 16'sd1;
			end
			if (move_y) begin
				next_state.cur_y = state.neg_y ? state.cur_y - 16'sd1 : state.cur_y + 16'sd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/clipped_line_rasterizer_unit.sv @@
// Top level of the clipped line rasterizer: input stage, line state and result register.
// A step result passes the input stage and then the result register before it is offered on m_axis.
// Throughput: one item per cycle while no held result stalls a step; the point and error loop
// closes through the combinational step unit, so back-to-back steps run at full rate.
// Loads update the line state and give no result; a held result stalls only a waiting step.
// Reset (arst_n low): line state, clip_left and all valid flags clear to zero.
`timescale 1ns / 1ps
`default_nettype none

module clipped_line_rasterizer_unit #(
	parameter int FRAME_WIDTH  = 2048,
	parameter int FRAME_HEIGHT = 1024
) (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        clip_left_wr_en,
	input  var logic [10:0] clip_left_wr_data,
	input  var logic        s_axis_tvalid,
	output var logic        s_axis_tready,
	// x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48], stroke_color[87:64]
	input  var logic [87:0] s_axis_tdata,
	// opcode[0]
	input  var logic [0:0]  s_axis_tuser,
	output var logic        m_axis_tvalid,
	input  var logic        m_axis_tready,
	// pixel_index[20:0], pixel_color[44:21], zero[47:45]
	output var logic [47:0] m_axis_tdata,
	// pixel_visible[0], line_done[1]
	output var logic [1:0]  m_axis_tuser
);
	import clr_pkg::*;

	logic [CLIP_W-1:0] clip_left_q;
	logic              valid_s1;
	line_item_t        item_s1;
	line_item_t        item_in;
	line_state_t       state_q;
	line_state_t       load_state;
	line_state_t       step_state;
	pixel_result_t     step_res;
	logic              out_valid_q;
	pixel_result_t     out_res_q;
	logic              out_free;
	logic              fire_s1;
	logic              is_step;

	assign item_in = '{opcode:       s_axis_tuser[0],
	                   x_start:      s_axis_tdata[15:0],
	                   y_start:      s_axis_tdata[31:16],
	                   x_end:        s_axis_tdata[47:32],
	                   y_end:        s_axis_tdata[63:48],
	                   stroke_color: s_axis_tdata[87:64]};

	assign is_step       = item_s1.opcode == OP_STEP;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire_s1       = valid_s1 && (!is_step || out_free);
	assign s_axis_tready = !valid_s1 || fire_s1;

	clr_setup u_setup (
		.item  (item_s1),
		.state (load_state)
	);

	clr_step #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_step (
		.state      (state_q),
		.clip_left  (clip_left_q),
		.result     (step_res),
		.next_state (step_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q <= '0;
		end else if (clip_left_wr_en) begin
			clip_left_q <= clip_left_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= is_step ? step_state : load_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && is_step;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_step) begin
			out_res_q <= step_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_res_q.pixel_color, out_res_q.pixel_index};
	assign m_axis_tuser  = {out_res_q.line_done, out_res_q.pixel_visible};

endmodule

`default_nettype wire

@@ bench/clipped_line_rasterizer_unit_tb.sv @@
// Self-checking stream bench for the clipped line rasterizer: line loads, pixel steps, clip moves.
`timescale 1ns / 1ps

module clipped_line_rasterizer_unit_tb;
	import clr_pkg::*;

	localparam int FRAME_W = 2048;
	localparam int FRAME_H = 1024;
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n = 1'b0;
	logic clip_left_wr_en = 1'b0;
	logic [CLIP_W-1:0] clip_left_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	clipped_line_rasterizer_unit #(
		.FRAME_WIDTH(FRAME_W),
		.FRAME_HEIGHT(FRAME_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.clip_left_wr_en(clip_left_wr_en),
		.clip_left_wr_data(clip_left_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	line_item_t line_items[$];
	pixel_result_t expected_pixels[$];
	line_item_t offered_item;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	logic rx_hold_req = 1'b0;
	logic rx_hold_done = 1'b0;
	int rx_hold_left = 0;

	coord_t pen_x = '0, pen_y = '0, goal_x = '0, goal_y = '0;
	logic [SPAN_W-1:0] run_x = '0, run_y = '0;
	logic dir_x_neg = 1'b0, dir_y_neg = 1'b0;
	logic signed [ERR_W-1:0] bres_err = '0;
	logic [COLOR_W-1:0] pen_color = '0;
	logic [CLIP_W-1:0] clip_mirror = '0;

	function automatic void apply_line_item(line_item_t it);
		pixel_result_t res;
		int xs, ys, xe, ye, px, py, err, e2;
		if (it.opcode == OP_LOAD) begin
			xs = it.x_start;
			ys = it.y_start;
			xe = it.x_end;
			ye = it.y_end;
			pen_x = it.x_start;
			pen_y = it.y_start;
			goal_x = it.x_end;
			goal_y = it.y_end;
			run_x = SPAN_W'((xs > xe) ? xs - xe : xe - xs);
			run_y = SPAN_W'((ys > ye) ? ys - ye : ye - ys);
			dir_x_neg = !(xs < xe);
			dir_y_neg = !(ys < ye);
			err = int'(run_x) - int'(run_y);
			bres_err = ERR_W'(err);
			pen_color = it.stroke_color;
			return;
		end
		res = '0;
		if (pen_x == goal_x && pen_y == goal_y) begin
			res.line_done = 1'b1;
		end else begin
			px = pen_x;
			py = pen_y;
			res.pixel_color = pen_color;
			res.pixel_visible = px >= int'(clip_mirror) && px < FRAME_W && py >= 0 && py < FRAME_H;
			if (res.pixel_visible)
				res.pixel_index = INDEX_W'(px + py * FRAME_W);
			err = bres_err;
			e2 = 2 * err;
			if (e2 > -int'(run_y)) begin
				err = err - int'(run_y);
				pen_x = dir_x_neg ? pen_x - 1'b1 : pen_x + 1'b1;
			end
			if (e2 < int'(run_x)) begin
				err = err + int'(run_x);
				pen_y = dir_y_neg ? pen_y - 1'b1 : pen_y + 1'b1;
			end
			bres_err = ERR_W'(err);
		end
		expected_pixels.push_back(res);
	endfunction

	task automatic report_mismatch(string what, pixel_result_t want, pixel_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: exp vis=%0d idx=%0d color=%06h done=%0d, got vis=%0d idx=%0d color=%06h done=%0d",
				$time, what, want.pixel_visible, want.pixel_index, want.pixel_color,
				want.line_done, got.pixel_visible, got.pixel_index, got.pixel_color,
				got.line_done);
	endtask

	always @(posedge clk) begin : line_driver
		if (s_axis_tvalid && s_axis_tready)
			apply_line_item(offered_item);
		if (!s_axis_tvalid || s_axis_tready) begin
			if (arst_n && line_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				offered_item = line_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {offered_item.stroke_color, offered_item.y_end, offered_item.x_end,
					offered_item.y_start, offered_item.x_start};
				s_axis_tuser <= offered_item.opcode;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : pixel_monitor
		pixel_result_t got;
		pixel_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pixel_index = m_axis_tdata[20:0];
			got.pixel_color = m_axis_tdata[44:21];
			got.pixel_visible = m_axis_tuser[0];
			got.line_done = m_axis_tuser[1];
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected transfer", '0, got);
			end else begin
				want = expected_pixels.pop_front();
				if (got.pixel_visible !== want.pixel_visible || got.pixel_index !== want.pixel_index ||
						got.pixel_color !== want.pixel_color || got.line_done !== want.line_done)
					report_mismatch("pixel mismatch", want, got);
			end
		end
		if (rx_hold_left != 0)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
	end

	always @(posedge clk) begin : rx_hold_counter
		if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_hold_req && !rx_hold_done) begin
			rx_hold_left <= 250;
			rx_hold_done <= 1'b1;
		end
	end

	task automatic push_line(int x0, int y0, int x1, int y1, int color, int steps);
		line_item_t it;
		it.opcode = OP_LOAD;
		it.x_start = COORD_W'(x0);
		it.y_start = COORD_W'(y0);
		it.x_end = COORD_W'(x1);
		it.y_end = COORD_W'(y1);
		it.stroke_color = COLOR_W'(color);
		line_items.push_back(it);
		it = '0;
		it.opcode = OP_STEP;
		repeat (steps) line_items.push_back(it);
	endtask

	task automatic push_steps(int steps);
		line_item_t it;
		it = '0;
		it.opcode = OP_STEP;
		repeat (steps) line_items.push_back(it);
	endtask

	task automatic queue_random_lines(int n_items);
		line_item_t it;
		int start_count, x0, y0, dx, dy, mode, steps;
		start_count = line_items.size();
		while (line_items.size() - start_count < n_items) begin
			mode = $urandom_range(99);
			if (mode < 45) begin
				x0 = int'($urandom_range(2120)) - 40;
				y0 = int'($urandom_range(1080)) - 30;
				dx = int'($urandom_range(48)) - 24;
				dy = int'($urandom_range(48)) - 24;
			end else if (mode < 65) begin
				x0 = int'(clip_mirror) + int'($urandom_range(16)) - 8;
				y0 = $urandom_range(FRAME_H - 1);
				dx = int'($urandom_range(24)) - 12;
				dy = int'($urandom_range(8)) - 4;
			end else if (mode < 85) begin
				x0 = $urandom_range(16'hFFFF);
				y0 = $urandom_range(16'hFFFF);
				dx = $urandom_range(16'hFFFF);
				dy = $urandom_range(16'hFFFF);
			end else begin
				it.opcode = 1'($urandom_range(1));
				it.x_start = COORD_W'($urandom_range(16'hFFFF));
				it.y_start = COORD_W'($urandom_range(16'hFFFF));
				it.x_end = COORD_W'($urandom_range(16'hFFFF));
				it.y_end = COORD_W'($urandom_range(16'hFFFF));
				it.stroke_color = COLOR_W'($urandom_range(24'hFFFFFF));
				line_items.push_back(it);
				continue;
			end
			if (mode < 65) begin
				steps = (dx < 0 ? -dx : dx);
				if ((dy < 0 ? -dy : dy) > steps)
					steps = (dy < 0 ? -dy : dy);
				steps += $urandom_range(2);
			end else begin
				steps = $urandom_range(1, 6);
			end
			push_line(x0, y0, x0 + dx, y0 + dy, $urandom_range(24'hFFFFFF), steps);
		end
	endtask

	task automatic drain;
		while (line_items.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_clip_left(logic [CLIP_W-1:0] value);
		@(posedge clk);
		clip_left_wr_en <= 1'b1;
		clip_left_wr_data <= value;
		clip_mirror = value;
		@(posedge clk);
		clip_left_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int clip_values[4];
		int send_pcts[4];
		int recv_pcts[4];
		clip_values = '{16, 2047, 0, 0};
		clip_values[2] = $urandom_range(1, 2046);
		send_pcts = '{0, 69, 0, 12};
		recv_pcts = '{0, 0, 69, 12};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_steps(1);
		push_line(-32768, -32768, 32767, 32767, 24'hFFFFFF, 3);
		push_line(32767, 32767, -32768, -32768, 24'h000000, 2);
		push_line(5, 5, 5, 5, 24'h123456, 1);
		push_line(2045, 1021, 2050, 1026, 24'hA5A5A5, 6);
		push_line(1, 5, -3, 2, 24'h5A5A5A, 4);
		drain();

		for (int p = 0; p < 4; p++) begin
			write_clip_left(CLIP_W'(clip_values[p]));
			send_idle_pct = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			if (p == 0)
				rx_hold_req <= 1'b1;
			queue_random_lines(380);
			drain();
		end

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
